/* rtl/core/skf_pkg.sv */
// Shared types, constants and control structs of the scalar Kalman filter.
package skf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W = 32;
    localparam int GAIN_W = 17;
    localparam int GAIN_FRAC = 16;
    localparam int DIV_STEPS = GAIN_W;
    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam int ADDR_W = 4;
    localparam int PROD_W = 51;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (GAIN_FRAC - 1));

    localparam logic [DATA_W-1:0] Q_RESET =
        DATA_W'(((64'd1 << FRAC_BITS) * 64'd5 + 64'd500) / 64'd1000);
    localparam logic [DATA_W-1:0] R_RESET = DATA_W'(64'd5 << FRAC_BITS);

    localparam logic [1:0] REG_PROCESS_NOISE = 2'd0;
    localparam logic [1:0] REG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [1:0] REG_INITIAL_ESTIMATE = 2'd2;
    localparam logic [1:0] REG_INITIAL_COVARIANCE = 2'd3;

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_RELOAD = 1'b1;

    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] measurement;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] estimate;
        logic [GAIN_W-1:0]        gain;
        logic                     error;
    } t_out;

    typedef struct packed {
        logic [DATA_W-1:0]        process_noise;
        logic [DATA_W-1:0]        measurement_noise;
        logic signed [DATA_W-1:0] initial_estimate;
        logic [DATA_W-1:0]        initial_covariance;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic reload;
        logic predict;
        logic den;
        logic num;
        logic div_step;
        logic mul_x;
        logic mul_p;
        logic commit;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic den_zero;
        logic out_free;
    } t_sts;

endpackage

/* rtl/core/scalar_kalman_filter.sv */
// Top level of the scalar Kalman filter: register file, controller and datapath.
//
// Usage: items arrive on the input channel (i_in_valid, o_in_stall, i_in_data) and each
// produces exactly one item on the output channel (o_out_valid, i_out_stall, o_out_data).
// A filter command runs predict, a 17-step restoring divide for the gain, two multiplies
// on one shared 18x33 multiplier and the state update; a reload command loads the initial
// estimate and covariance, and a zero denominator skips the divide and the multiplies.
// One item is in work at a time: a new item is accepted only after the last one reaches
// the output register, and o_in_stall is low only while the block waits for work.
// A finished item sits in the output register; the next item is accepted while it
// waits, and the block holds a second result until the receiver drops i_out_stall.
// A zero divisor (p + q + r equal to zero) keeps the state and returns error set.
// Reset clears estimate and covariance and loads the register defaults. The user must
// write registers through the APB-style port only while the block is idle; the block
// does not enforce it.
module scalar_kalman_filter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  skf_pkg::t_in               i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output skf_pkg::t_out              o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [skf_pkg::ADDR_W-1:0] paddr,
    input  logic [skf_pkg::DATA_W-1:0] pwdata,
    output logic [skf_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    skf_pkg::t_cfg cfg;
    skf_pkg::t_cmd cmd;
    skf_pkg::t_sts sts;

    skf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    skf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_data.command),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    skf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* rtl/core/skf_regs.sv */
// Configuration register file of the scalar Kalman filter with its APB-style port.
module skf_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [skf_pkg::ADDR_W-1:0]       paddr,
    input  logic [skf_pkg::DATA_W-1:0]       pwdata,
    output logic [skf_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    output skf_pkg::t_cfg                    o_cfg
);

    skf_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.process_noise      <= skf_pkg::Q_RESET;
            r_cfg.measurement_noise  <= skf_pkg::R_RESET;
            r_cfg.initial_estimate   <= '0;
            r_cfg.initial_covariance <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                skf_pkg::REG_PROCESS_NOISE:      r_cfg.process_noise <= pwdata;
                skf_pkg::REG_MEASUREMENT_NOISE:  r_cfg.measurement_noise <= pwdata;
                skf_pkg::REG_INITIAL_ESTIMATE:   r_cfg.initial_estimate <= pwdata;
                skf_pkg::REG_INITIAL_COVARIANCE: r_cfg.initial_covariance <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            skf_pkg::REG_PROCESS_NOISE:      prdata = r_cfg.process_noise;
            skf_pkg::REG_MEASUREMENT_NOISE:  prdata = r_cfg.measurement_noise;
            skf_pkg::REG_INITIAL_ESTIMATE:   prdata = r_cfg.initial_estimate;
            skf_pkg::REG_INITIAL_COVARIANCE: prdata = r_cfg.initial_covariance;
            default:                         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/skf_ctrl.sv */
// Sequencing state machine of the scalar Kalman filter.
module skf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_command,
    output logic          o_in_stall,
    input  skf_pkg::t_sts i_sts,
    output skf_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RELOAD = 4'd1;
    localparam logic [3:0] S_PRED   = 4'd2;
    localparam logic [3:0] S_DEN    = 4'd3;
    localparam logic [3:0] S_NUM    = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_MULX   = 4'd6;
    localparam logic [3:0] S_MULP   = 4'd7;
    localparam logic [3:0] S_UPD    = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    localparam logic [skf_pkg::CNT_W-1:0] LAST_STEP = skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1);

    logic [3:0]                r_state, n_state;
    logic [skf_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid & (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_command == skf_pkg::CMD_RELOAD) ? S_RELOAD : S_PRED;
                end
            end
            S_RELOAD: begin
                o_cmd.reload = 1'b1;
                n_state = S_DONE;
            end
            S_PRED: begin
                o_cmd.predict = 1'b1;
                n_state = S_DEN;
            end
            S_DEN: begin
                o_cmd.den = 1'b1;
                n_state = S_NUM;
            end
            S_NUM: begin
                o_cmd.num = 1'b1;
                n_cnt = '0;
                n_state = i_sts.den_zero ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_MULX;
                end
            end
            S_MULX: begin
                o_cmd.mul_x = 1'b1;
                n_state = S_MULP;
            end
            S_MULP: begin
                o_cmd.mul_p = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.commit = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= LAST_STEP))
        else $error("Divider step count ran past the last quotient bit.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_RELOAD || r_state == S_PRED))
        else $error("Accepted item did not start a reload or a filter step.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> ($past(r_state) == S_MULP))
        else $error("State update reached without both multiplies.");

endmodule

/* rtl/core/skf_dp.sv */
// Datapath of the scalar Kalman filter: state, divider, shared multiplier and result register.
module skf_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  skf_pkg::t_in  i_in_data,
    input  skf_pkg::t_cfg i_cfg,
    input  skf_pkg::t_cmd i_cmd,
    output skf_pkg::t_sts o_sts,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output skf_pkg::t_out o_out_data
);

    localparam int DW = skf_pkg::DATA_W;
    localparam int GW = skf_pkg::GAIN_W;
    localparam int PW = skf_pkg::PROD_W;
    localparam int NW = DW + skf_pkg::GAIN_FRAC + 1;
    localparam int SW = PW - skf_pkg::GAIN_FRAC;

    logic signed [DW-1:0] r_est;
    logic [DW-1:0]        r_cov;
    logic signed [DW-1:0] r_meas;
    logic [DW-1:0]        r_p1;
    logic signed [DW:0]   r_diff;
    logic [DW:0]          r_den;
    logic                 r_zero;
    logic [DW:0]          r_rem;
    logic [GW-1:0]        r_q;
    logic [GW-1:0]        r_gain;
    logic                 r_err;
    logic signed [PW-1:0] r_prod;
    logic signed [DW-1:0] r_xnew;
    logic                 r_ovalid;
    skf_pkg::t_out        r_out;

    logic [DW:0]          p1_sum;
    logic [DW-1:0]        p1_sat;
    logic [DW:0]          den_sum;
    logic [NW-1:0]        num;
    logic [DW+1:0]        div_t;
    logic                 div_ge;
    logic [DW+1:0]        div_sub;
    logic [GW-1:0]        gain_c;
    logic signed [GW:0]   mul_a;
    logic signed [DW:0]   mul_b;
    logic signed [PW-1:0] mul_y;
    logic signed [PW-1:0] x_round;
    logic signed [SW-1:0] x_shift;
    logic signed [SW:0]   x_sum;
    logic signed [DW-1:0] x_sat;
    logic [PW-1:0]        p_round;
    logic [SW-1:0]        p_shift;
    logic [DW-1:0]        p_sat;

    assign p1_sum  = {1'b0, r_cov} + {1'b0, i_cfg.process_noise};
    assign p1_sat  = p1_sum[DW] ? {DW{1'b1}} : p1_sum[DW-1:0];
    assign den_sum = {1'b0, r_p1} + {1'b0, i_cfg.measurement_noise};
    assign num     = {1'b0, r_p1, {skf_pkg::GAIN_FRAC{1'b0}}}
                   + {{(NW-DW){1'b0}}, r_den[DW:1]};

    assign div_t   = {r_rem, r_q[GW-1]};
    assign div_ge  = (div_t >= {1'b0, r_den});
    assign div_sub = div_t - {1'b0, r_den};
    assign gain_c  = (r_q > skf_pkg::GAIN_ONE) ? skf_pkg::GAIN_ONE : r_q;

    always_comb begin
        if (i_cmd.mul_p) begin
            mul_a = $signed({1'b0, skf_pkg::GAIN_ONE - r_gain});
            mul_b = $signed({1'b0, r_p1});
        end else begin
            mul_a = $signed({1'b0, gain_c});
            mul_b = r_diff;
        end
    end
    assign mul_y = PW'(mul_a) * PW'(mul_b);

    assign x_round = r_prod + $signed(skf_pkg::ROUND_HALF);
    assign x_shift = x_round[PW-1:skf_pkg::GAIN_FRAC];
    assign x_sum   = {{(SW+1-DW){r_est[DW-1]}}, r_est} + {x_shift[SW-1], x_shift};

    always_comb begin
        if (x_sum[SW:DW-1] == {(SW+2-DW){1'b0}} || x_sum[SW:DW-1] == {(SW+2-DW){1'b1}}) begin
            x_sat = x_sum[DW-1:0];
        end else if (x_sum[SW]) begin
            x_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            x_sat = {1'b0, {(DW-1){1'b1}}};
        end
    end

    assign p_round = r_prod + skf_pkg::ROUND_HALF;
    assign p_shift = p_round[PW-1:skf_pkg::GAIN_FRAC];
    assign p_sat   = (|p_shift[SW-1:DW]) ? {DW{1'b1}} : p_shift[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= '0;
            r_cov <= '0;
        end else if (i_cmd.reload) begin
            r_est <= i_cfg.initial_estimate;
            r_cov <= i_cfg.initial_covariance;
        end else if (i_cmd.commit) begin
            r_est <= r_xnew;
            r_cov <= p_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_meas <= i_in_data.measurement;
            r_gain <= '0;
            r_err  <= 1'b0;
        end
        if (i_cmd.predict) begin
            r_p1   <= p1_sat;
            r_diff <= {r_meas[DW-1], r_meas} - {r_est[DW-1], r_est};
        end
        if (i_cmd.den) begin
            r_den  <= den_sum;
            r_zero <= (den_sum == '0);
        end
        if (i_cmd.num) begin
            r_rem <= {1'b0, num[NW-1:GW]};
            r_q   <= num[GW-1:0];
            r_err <= r_zero;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_sub[DW:0] : div_t[DW:0];
            r_q   <= {r_q[GW-2:0], div_ge};
        end
        if (i_cmd.mul_x) begin
            r_gain <= gain_c;
            r_prod <= mul_y;
        end
        if (i_cmd.mul_p) begin
            r_xnew <= x_sat;
            r_prod <= mul_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.estimate <= r_est;
            r_out.gain     <= r_gain;
            r_out.error    <= r_err;
        end
    end

    assign o_sts.den_zero = r_zero;
    assign o_sts.out_free = !r_ovalid || !i_out_stall;
    assign o_out_valid    = r_ovalid;
    assign o_out_data     = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.error) |-> (r_out.gain == '0))
        else $error("Item flagged with a zero denominator carries a nonzero gain.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_out.gain <= skf_pkg::GAIN_ONE))
        else $error("Gain above one.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.num && !r_zero) |=> (r_rem < r_den))
        else $error("Divider started with a partial remainder not below the divisor.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_cov <= $past(r_p1)))
        else $error("Updated covariance exceeds the predicted covariance.");

endmodule

/* tb/scalar_kalman_filter_checker.sv */
`timescale 1ns / 1ps
// Checker for the scalar Kalman filter: predicts each result and compares it with the output.
module scalar_kalman_filter_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  skf_pkg::t_in               i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  skf_pkg::t_out              i_out_data,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [skf_pkg::ADDR_W-1:0] i_paddr,
    input  logic [skf_pkg::DATA_W-1:0] i_pwdata,
    input  logic                       i_pready,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked,
    output int                         o_reloads,
    output int                         o_zero_den,
    output int                         o_unity_gain
);

    localparam longint EST_MAX = 64'sd2147483647;
    localparam longint EST_MIN = -64'sd2147483648;
    localparam logic [63:0] COV_MAX = 64'hFFFF_FFFF;
    localparam logic [63:0] HALF_LSB = 64'd1 << (skf_pkg::GAIN_FRAC - 1);
    localparam logic [63:0] UNITY = 64'(skf_pkg::GAIN_ONE);

    skf_pkg::t_cfg                     cfg_model;
    logic signed [skf_pkg::DATA_W-1:0] est_model;
    logic [skf_pkg::DATA_W-1:0]        cov_model;
    skf_pkg::t_out                     expected_results[$];
    skf_pkg::t_out                     want;

    assign o_pending = expected_results.size();

    function automatic skf_pkg::t_out kalman_step(skf_pkg::t_in item);
        skf_pkg::t_out res;
        logic [63:0]   p1;
        logic [63:0]   den;
        logic [63:0]   gain;
        logic [63:0]   pn;
        longint        diff;
        longint        x;
        res = '0;
        if (item.command == skf_pkg::CMD_RELOAD) begin
            est_model = cfg_model.initial_estimate;
            cov_model = cfg_model.initial_covariance;
            o_reloads++;
        end else begin
            p1 = 64'(cov_model) + 64'(cfg_model.process_noise);
            if (p1 > COV_MAX) begin
                p1 = COV_MAX;
            end
            den = p1 + 64'(cfg_model.measurement_noise);
            if (den == 64'd0) begin
                res.error = 1'b1;
                o_zero_den++;
            end else begin
                gain = ((p1 << skf_pkg::GAIN_FRAC) + den / 2) / den;
                if (gain > UNITY) begin
                    gain = UNITY;
                end
                diff = longint'($signed(item.measurement)) - longint'(est_model);
                x = longint'(est_model)
                    + ((longint'(gain) * diff + longint'(HALF_LSB)) >>> skf_pkg::GAIN_FRAC);
                if (x > EST_MAX) begin
                    x = EST_MAX;
                end
                if (x < EST_MIN) begin
                    x = EST_MIN;
                end
                pn = (p1 * (UNITY - gain) + HALF_LSB) >> skf_pkg::GAIN_FRAC;
                if (pn > COV_MAX) begin
                    pn = COV_MAX;
                end
                est_model = x[skf_pkg::DATA_W-1:0];
                cov_model = pn[skf_pkg::DATA_W-1:0];
                res.gain = gain[skf_pkg::GAIN_W-1:0];
                if (gain == UNITY) begin
                    o_unity_gain++;
                end
            end
        end
        res.estimate = est_model;
        return res;
    endfunction

    function automatic int field_mismatch(string field, logic [63:0] want_v,
                                          logic [63:0] got_v);
        if (want_v === got_v) begin
            return 0;
        end
        $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_model.process_noise = skf_pkg::Q_RESET;
            cfg_model.measurement_noise = skf_pkg::R_RESET;
            cfg_model.initial_estimate = '0;
            cfg_model.initial_covariance = '0;
            est_model = '0;
            cov_model = '0;
            expected_results.delete();
            o_fail_count = 0;
            o_checked = 0;
            o_reloads = 0;
            o_zero_den = 0;
            o_unity_gain = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[skf_pkg::ADDR_W-1:2])
                    skf_pkg::REG_PROCESS_NOISE: cfg_model.process_noise = i_pwdata;
                    skf_pkg::REG_MEASUREMENT_NOISE: cfg_model.measurement_noise = i_pwdata;
                    skf_pkg::REG_INITIAL_ESTIMATE: cfg_model.initial_estimate = i_pwdata;
                    skf_pkg::REG_INITIAL_COVARIANCE: cfg_model.initial_covariance = i_pwdata;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item pending: estimate 0x%0h",
                           i_out_data.estimate);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    o_fail_count += field_mismatch("estimate", want.estimate,
                                                   i_out_data.estimate);
                    o_fail_count += field_mismatch("gain", want.gain, i_out_data.gain);
                    o_fail_count += field_mismatch("error", want.error, i_out_data.error);
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(kalman_step(i_in_data));
            end
        end
    end

endmodule

/* tb/scalar_kalman_filter_test.sv */
`timescale 1ns / 1ps
// Testbench top for the scalar Kalman filter: stimulus, register setup and the verdict.
module scalar_kalman_filter_test;

    localparam int LONG_HOLD = 300;
    localparam int SUB_PHASES = 5;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    skf_pkg::t_in                  in_data = '0;
    logic                          out_stall = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [skf_pkg::ADDR_W-1:0]    paddr = '0;
    logic [skf_pkg::DATA_W-1:0]    pwdata = '0;

    logic                          in_stall;
    logic                          out_valid;
    skf_pkg::t_out                 out_data;
    logic [skf_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    int                            fail_count;
    int                            pending;
    int                            checked;
    int                            reloads;
    int                            zero_den;
    int                            unity_gain;

    int                            send_idle = 31;
    int                            recv_idle = 65;
    bit                            hold_request = 1'b0;
    int                            hold_count;
    int                            items_sent = 0;
    int                            settings = 0;
    logic signed [31:0]            trend = '0;
    int                            phase;
    int                            sub;

    scalar_kalman_filter uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    scalar_kalman_filter_checker result_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_reloads   (reloads),
        .o_zero_den  (zero_den),
        .o_unity_gain(unity_gain)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                for (hold_count = 0; hold_count < LONG_HOLD; hold_count++) begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    task automatic send_item(input logic cmd, input logic [skf_pkg::DATA_W-1:0] meas);
        skf_pkg::t_in item;
        item.command = cmd;
        item.measurement = meas;
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [skf_pkg::DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= skf_pkg::ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [skf_pkg::DATA_W-1:0] q,
                              input logic [skf_pkg::DATA_W-1:0] r,
                              input logic [skf_pkg::DATA_W-1:0] x0,
                              input logic [skf_pkg::DATA_W-1:0] p0);
        drain();
        write_reg(skf_pkg::REG_PROCESS_NOISE, q);
        write_reg(skf_pkg::REG_MEASUREMENT_NOISE, r);
        write_reg(skf_pkg::REG_INITIAL_ESTIMATE, x0);
        write_reg(skf_pkg::REG_INITIAL_COVARIANCE, p0);
        settings++;
    endtask

    function automatic logic [skf_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return $urandom_range(1, 255);
            2: return $urandom_range(256, 1 << 20);
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [skf_pkg::DATA_W-1:0] pick_measurement();
        int sel;
        sel = $urandom_range(99);
        trend = trend + 32'($urandom_range(0, 2047)) - 32'd1024;
        if (sel < 10) begin
            case ($urandom_range(3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (sel < 35) begin
            return $urandom();
        end
        return trend + 32'($urandom_range(0, 262143)) - 32'd131072;
    endfunction

    task automatic run_random(input int count);
        repeat (count) begin
            if ($urandom_range(99) < 4) begin
                send_item(skf_pkg::CMD_RELOAD, $urandom());
            end else begin
                send_item(skf_pkg::CMD_FILTER, pick_measurement());
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults straight out of reset.
        send_item(skf_pkg::CMD_FILTER, 32'h7FFF_FFFF);
        send_item(skf_pkg::CMD_FILTER, 32'h8000_0000);
        send_item(skf_pkg::CMD_FILTER, 32'h0000_0000);
        send_item(skf_pkg::CMD_RELOAD, 32'hFFFF_FFFF);

        // No noise and no covariance: the denominator is zero and the state holds.
        set_config(32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0);
        send_item(skf_pkg::CMD_RELOAD, 32'd0);
        send_item(skf_pkg::CMD_FILTER, 32'h8000_0000);
        send_item(skf_pkg::CMD_FILTER, 32'h0001_0000);

        // Unit gain collapses the covariance, so the next step hits a zero denominator.
        set_config(32'd0, 32'd0, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(skf_pkg::CMD_RELOAD, 32'd0);
        send_item(skf_pkg::CMD_FILTER, 32'h7FFF_FFFF);
        send_item(skf_pkg::CMD_FILTER, 32'd0);

        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(skf_pkg::CMD_RELOAD, 32'h8000_0000);
        send_item(skf_pkg::CMD_FILTER, 32'h7FFF_FFFF);
        send_item(skf_pkg::CMD_FILTER, 32'h8000_0000);
        send_item(skf_pkg::CMD_FILTER, 32'hFFFF_FFFF);

        set_config(32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd0);
        send_item(skf_pkg::CMD_RELOAD, 32'h7FFF_FFFF);
        send_item(skf_pkg::CMD_FILTER, 32'h8000_0000);
        send_item(skf_pkg::CMD_FILTER, 32'h7FFF_FFFF);

        set_config(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd1);
        send_item(skf_pkg::CMD_RELOAD, 32'd0);
        send_item(skf_pkg::CMD_FILTER, 32'h7FFF_FFFF);
        send_item(skf_pkg::CMD_FILTER, 32'h8000_0000);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle = 31;
                    recv_idle = 65;
                end
                1: begin
                    send_idle = 65;
                    recv_idle = 31;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            for (sub = 0; sub < SUB_PHASES; sub++) begin
                if (sub == 0) begin
                    set_config($urandom_range(1, 4096), $urandom_range(1 << 16, 1 << 20),
                               trend, $urandom_range(1 << 16, 1 << 22));
                end else begin
                    set_config(pick_word(), pick_word(), pick_word(), pick_word());
                end
                send_item(skf_pkg::CMD_RELOAD, $urandom());
                run_random(50);
                if (sub == 2) begin
                    hold_request = 1'b1;
                end
                if (sub == 3) begin
                    drain();
                end
                run_random(52);
            end
        end

        drain();
        repeat (60) @(posedge clk);

        $display("Sent %0d items over %0d register settings and three idling mixes.",
                 items_sent, settings);
        $display("Checked %0d results: %0d reloads, %0d zero-denominator, %0d unit-gain.",
                 checked, reloads, zero_den, unity_gain);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
